>>> hw/rtl/m4i_pkg.sv
package m4i_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SH_W   = PROD_W - FRAC_W;
  localparam int ACC_W  = DATA_W + 4;
  localparam int QUO_W  = 2 * FRAC_W + 1;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // One cofactor term: pair operands a and b, third operand c (all as
  // element store addresses) and whether the term is subtracted.
  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] c;
    logic       sub;
  } term_t;

  localparam logic [3:0] PAIR_A [12] = '{4'd10, 4'd11, 4'd9, 4'd11, 4'd9, 4'd10,
                                          4'd8, 4'd11, 4'd8, 4'd10, 4'd8, 4'd9};
  localparam logic [3:0] PAIR_B [12] = '{4'd15, 4'd14, 4'd15, 4'd13, 4'd14, 4'd13,
                                          4'd15, 4'd12, 4'd14, 4'd12, 4'd13, 4'd12};

  localparam logic [3:0] COF_P [8][6] = '{
    '{4'd0, 4'd3, 4'd4, 4'd1, 4'd2, 4'd5},
    '{4'd1, 4'd6, 4'd9, 4'd0, 4'd7, 4'd8},
    '{4'd2, 4'd7, 4'd10, 4'd3, 4'd6, 4'd11},
    '{4'd5, 4'd8, 4'd11, 4'd4, 4'd9, 4'd10},
    '{4'd1, 4'd2, 4'd5, 4'd0, 4'd3, 4'd4},
    '{4'd0, 4'd7, 4'd8, 4'd1, 4'd6, 4'd9},
    '{4'd3, 4'd6, 4'd11, 4'd2, 4'd7, 4'd10},
    '{4'd4, 4'd9, 4'd10, 4'd5, 4'd8, 4'd11}
  };

  localparam logic [2:0] COF_S [8][6] = '{
    '{3'd5, 3'd6, 3'd7, 3'd5, 3'd6, 3'd7},
    '{3'd4, 3'd6, 3'd7, 3'd4, 3'd6, 3'd7},
    '{3'd4, 3'd5, 3'd7, 3'd4, 3'd5, 3'd7},
    '{3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd6},
    '{3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd3},
    '{3'd0, 3'd2, 3'd3, 3'd0, 3'd2, 3'd3},
    '{3'd0, 3'd1, 3'd3, 3'd0, 3'd1, 3'd3},
    '{3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2}
  };

  // Index into the transposed matrix -> row-major store address.
  function automatic logic [3:0] s_addr(input logic [3:0] idx);
    return {idx[1:0], idx[3:2]};
  endfunction

  function automatic term_t term_lookup(input logic [3:0] cof, input logic [2:0] t);
    term_t      r;
    logic [3:0] p;
    logic [3:0] pa;
    logic [3:0] pb;
    p     = COF_P[cof[2:0]][t];
    pa    = PAIR_A[p];
    pb    = PAIR_B[p];
    r.a   = s_addr({~cof[3], pa[2:0]});
    r.b   = s_addr({~cof[3], pb[2:0]});
    r.c   = s_addr({cof[3], COF_S[cof[2:0]][t]});
    r.sub = (t > 3'd2);
    return r;
  endfunction

  // Floor shift by the fraction width, then saturate to the data width.
  function automatic word_t sat_shift(input prod_t p);
    logic [SH_W-1:0] sh;
    sh = p[PROD_W-1:FRAC_W];
    if (sh[SH_W-1:DATA_W-1] == '0 || sh[SH_W-1:DATA_W-1] == '1) begin
      return word_t'(sh[DATA_W-1:0]);
    end
    return p[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  function automatic word_t sat_acc(input acc_t a);
    if (a[ACC_W-1:DATA_W-1] == '0 || a[ACC_W-1:DATA_W-1] == '1) begin
      return word_t'(a[DATA_W-1:0]);
    end
    return a[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

endpackage

>>> hw/rtl/matrix4_inverse_cramer_top.sv
// 4x4 matrix inverse by cofactors (Cramer's rule), signed Q16.16.
//
// Input channel: one matrix element per request on in_element, row-major,
// sixteen requests per matrix. The element store is a 16-entry memory with
// registered reads. in_stall is low only while elements are being loaded.
// After the sixteenth element the block computes all sixteen cofactors
// (96 terms, each through states S_TA to S_TE on one shared multiplier,
// plus a write state S_CW per cofactor), the determinant (four products,
// each through S_DA to S_DC), a 33-step bit-serial reciprocal, and then
// emits the sixteen inverse elements on the output channel, row-major,
// each with its position, is_last on the final one and singular when the
// determinant is zero (elements then zero). Results are held in an output
// register; while out_stall is high the request stays and the block waits.
// Reset (rst_n low, synchronous) returns the block to loading the first
// element of a matrix; a new matrix loads only after the last result is taken.
module matrix4_inverse_cramer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_element,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_inv_element,
  output logic [3:0]  out_position,
  output logic        out_is_last,
  output logic        out_singular
);

  typedef enum logic [3:0] {
    S_LOAD, S_TA, S_TB, S_TC, S_TD, S_TE, S_CW,
    S_DA, S_DB, S_DC, S_DV, S_DW, S_OA, S_OB, S_OC, S_OD
  } state_t;

  state_t              state_r;
  logic [3:0]          load_cnt_r;
  logic [3:0]          k_r;
  logic [2:0]          term_r;
  m4i_pkg::word_t      elem_mem [16];
  m4i_pkg::word_t      cof_mem [16];
  m4i_pkg::word_t      rd0_r;
  m4i_pkg::word_t      rd1_r;
  m4i_pkg::word_t      cof_rd_r;
  m4i_pkg::word_t      pair_r;
  m4i_pkg::prod_t      prod_r;
  m4i_pkg::acc_t       acc_r;
  m4i_pkg::word_t      det_r;
  m4i_pkg::word_t      recip_r;
  logic                sing_r;
  logic                out_valid_r;
  m4i_pkg::word_t      out_data_r;
  logic [3:0]          out_pos_r;
  logic                out_last_r;
  logic [3:0]          raddr0;
  logic [3:0]          raddr1;
  m4i_pkg::term_t      term;
  m4i_pkg::word_t      mul_a;
  m4i_pkg::word_t      mul_b;
  m4i_pkg::word_t      shifted;
  logic                in_acc;
  logic                div_start;
  logic                div_done;
  logic [m4i_pkg::QUO_W-1:0] div_quot;
  m4i_pkg::word_t      det_sat;
  logic [31:0]         det_mag;

  assign in_acc = in_valid && (state_r == S_LOAD);
  assign term   = m4i_pkg::term_lookup(k_r, term_r);
  assign shifted = m4i_pkg::sat_shift(prod_r);

  // Element store read addresses, chosen by the sequencer.
  always_comb begin
    raddr0 = term.a;
    raddr1 = term.b;
    unique case (state_r)
      S_TB, S_TC, S_TD: raddr0 = term.c;
      S_DA, S_DB:       raddr0 = m4i_pkg::s_addr(k_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      elem_mem[load_cnt_r] <= in_element;
    end
    rd0_r    <= elem_mem[raddr0];
    rd1_r    <= elem_mem[raddr1];
    cof_rd_r <= cof_mem[k_r];
    if (state_r == S_CW) begin
      cof_mem[k_r] <= m4i_pkg::sat_acc(acc_r);
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = rd0_r;
    mul_b = rd1_r;
    unique case (state_r)
      S_TD: begin
        mul_a = pair_r;
        mul_b = rd0_r;
      end
      S_DB: mul_b = cof_rd_r;
      S_OB: begin
        mul_a = cof_rd_r;
        mul_b = recip_r;
      end
      default: ;
    endcase
  end

  // The determinant is the saturated accumulator in S_DV; its magnitude
  // feeds the divider, and a zero determinant never starts it.
  assign det_sat   = m4i_pkg::sat_acc(acc_r);
  assign det_mag   = det_sat[31] ? 32'(-det_sat) : 32'(det_sat);
  assign div_start = (state_r == S_DV) && (det_sat != '0);

  m4i_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (det_mag),
    .done    (div_done),
    .quot    (div_quot)
  );

  always_ff @(posedge clk) begin
    prod_r <= m4i_pkg::prod_t'(mul_a * mul_b);
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      k_r         <= '0;
      term_r      <= '0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            load_cnt_r <= load_cnt_r + 4'd1;
            if (load_cnt_r == 4'd15) begin
              k_r     <= '0;
              term_r  <= '0;
              acc_r   <= '0;
              state_r <= S_TA;
            end
          end
        end
        S_TA: state_r <= S_TB;
        S_TB: state_r <= S_TC;
        S_TC: begin
          pair_r  <= shifted;
          state_r <= S_TD;
        end
        S_TD: state_r <= S_TE;
        S_TE: begin
          acc_r <= term.sub ? acc_r - m4i_pkg::acc_t'(shifted)
                            : acc_r + m4i_pkg::acc_t'(shifted);
          if (term_r == 3'd5) begin
            state_r <= S_CW;
          end else begin
            term_r  <= term_r + 3'd1;
            state_r <= S_TA;
          end
        end
        S_CW: begin
          acc_r  <= '0;
          term_r <= '0;
          k_r    <= k_r + 4'd1;
          state_r <= (k_r == 4'd15) ? S_DA : S_TA;
        end
        S_DA: state_r <= S_DB;
        S_DB: state_r <= S_DC;
        S_DC: begin
          acc_r <= acc_r + m4i_pkg::acc_t'(shifted);
          k_r   <= k_r + 4'd1;
          state_r <= (k_r == 4'd3) ? S_DV : S_DA;
        end
        S_DV: begin
          det_r   <= det_sat;
          k_r     <= '0;
          sing_r  <= (det_sat == '0);
          recip_r <= '0;
          state_r <= (det_sat == '0) ? S_OA : S_DW;
        end
        S_DW: begin
          if (div_done) begin
            // Sign the quotient and saturate to the data width.
            if (!det_r[31]) begin
              recip_r <= (div_quot > m4i_pkg::QUO_W'(32'h7fff_ffff)) ?
                         32'sh7fff_ffff : 32'(div_quot);
            end else begin
              recip_r <= (div_quot >= m4i_pkg::QUO_W'(33'h0_8000_0000)) ?
                         32'sh8000_0000 : 32'(-div_quot);
            end
            state_r <= S_OA;
          end
        end
        S_OA: state_r <= S_OB;
        S_OB: state_r <= S_OC;
        S_OC: begin
          out_valid_r <= 1'b1;
          out_data_r  <= sing_r ? '0 : shifted;
          out_pos_r   <= k_r;
          out_last_r  <= (k_r == 4'd15);
          state_r     <= S_OD;
        end
        S_OD: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            k_r         <= k_r + 4'd1;
            state_r     <= (k_r == 4'd15) ? S_LOAD : S_OA;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign in_stall        = (state_r != S_LOAD);
  assign out_valid       = out_valid_r;
  assign out_inv_element = out_data_r;
  assign out_position    = out_pos_r;
  assign out_is_last     = out_last_r;
  assign out_singular    = sing_r;

endmodule

>>> hw/rtl/m4i_div.sv
// Restoring divider: 2^(2*FRAC_W) / divisor, one quotient bit per cycle.
module m4i_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [m4i_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [m4i_pkg::QUO_W-1:0] quot
);

  logic [m4i_pkg::QUO_W-1:0]  num_r;
  logic [m4i_pkg::QUO_W-1:0]  quo_r;
  logic [m4i_pkg::DATA_W-1:0] rem_r;
  logic [m4i_pkg::DATA_W-1:0] dvs_r;
  logic [5:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [m4i_pkg::DATA_W:0]   trial;
  logic [m4i_pkg::DATA_W:0]   diff;

  assign trial = {rem_r, num_r[m4i_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(m4i_pkg::QUO_W);
        num_r  <= {1'b1, {(m4i_pkg::QUO_W-1){1'b0}}};
        quo_r  <= '0;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        num_r <= {num_r[m4i_pkg::QUO_W-2:0], 1'b0};
        if (!diff[m4i_pkg::DATA_W]) begin
          rem_r <= diff[m4i_pkg::DATA_W-1:0];
          quo_r <= {quo_r[m4i_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_r <= trial[m4i_pkg::DATA_W-1:0];
          quo_r <= {quo_r[m4i_pkg::QUO_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
